// ----- design/fpcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Frequency/period counter select package
// Shared widths, codes and constant tables of the reciprocal counter stage.
// ----------------------------------------------------------------------------
package fpcs_pkg;

  localparam int CountW   = 32;
  localparam int FreqW    = 46;
  localparam int NumW     = 44;
  localparam int ScaleW   = 14;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 2;
  localparam int WideW    = FreqW + 4;

  localparam logic [CountW-1:0] LowCountLimit = 32'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_METER   = 2'd0,
    CFG_GATE    = 2'd1,
    CFG_REF     = 2'd2,
    CFG_PERIODS = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KIND_FREQ   = 1'b0,
    KIND_PERIOD = 1'b1
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  // Millihertz per gate count.
  function automatic logic [ScaleW-1:0] gate_scale(input logic meter,
                                                   input logic [1:0] gate);
    logic [ScaleW-1:0] s;
    if (!meter) begin
      s = 14'd10000;
    end else begin
      case (gate)
        2'd0:    s = 14'd10000;
        2'd1:    s = 14'd1000;
        default: s = 14'd100;
      endcase
    end
    return s;
  endfunction

  // Reference factor times periods factor times 1000, a power of ten.
  function automatic logic [NumW-1:0] period_numerator(input logic meter,
                                                       input logic [1:0] ref_sel,
                                                       input logic [1:0] per_sel);
    logic [1:0]      p;
    logic [2:0]      e;
    logic [NumW-1:0] n;
    p = (per_sel == 2'd3) ? 2'd2 : per_sel;
    e = {1'b0, ref_sel} + {1'b0, p};
    if (!meter) begin
      n = 44'd1000000000;
    end else begin
      case (e)
        3'd0:    n = 44'd100000000;
        3'd1:    n = 44'd1000000000;
        3'd2:    n = 44'd10000000000;
        3'd3:    n = 44'd100000000000;
        3'd4:    n = 44'd1000000000000;
        default: n = 44'd10000000000000;
      endcase
    end
    return n;
  endfunction

endpackage

// ----- design/fpcs_if.sv -----
// ----------------------------------------------------------------------------
// Frequency/period counter select channels
// Valid/ready channels for count items and frequency result items.
// ----------------------------------------------------------------------------
interface fpcs_in_if
  import fpcs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CountW-1:0] count;

  modport source (output valid, output kind, output count, input ready);
  modport sink   (input valid, input kind, input count, output ready);
endinterface

interface fpcs_out_if
  import fpcs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [FreqW-1:0] frequency_mhz;
  logic             unstable;

  modport source (output valid, output frequency_mhz, output unstable, input ready);
  modport sink   (input valid, input frequency_mhz, input unstable, output ready);
endinterface

// ----- design/freq_period_counter_select.sv -----
// ----------------------------------------------------------------------------
// Frequency/period counter select
// Turns gate counts and period counts into a frequency in millihertz with a
// stability flag, switching between the two counting modes.
// ----------------------------------------------------------------------------
// A frequency count passes the multiply, scale and done states; a period count
// other than zero passes the 44-step restoring divider, then scale and done.
// A count that gives no result is absorbed in the cycle it is taken.
// The block takes one item at a time; a finished result waits in the output
// register while the next item is already being taken.
// Reset restores the register defaults, frequency mode and a zero history.
module freq_period_counter_select
  import fpcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  fpcs_in_if.sink             in_i,
  fpcs_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  state_e            state_q;
  logic              period_mode_q;
  logic              meter_q;
  logic [1:0]        gate_q;
  logic [1:0]        ref_q;
  logic [1:0]        per_q;
  logic [CountW-1:0] count_q;
  logic [FreqW-1:0]  freq_q;
  logic [FreqW-1:0]  prev_q;
  logic [WideW-1:0]  f10_q;
  logic [WideW-1:0]  p9_q;
  logic [WideW-1:0]  p11_q;
  logic              out_valid_q;
  logic [FreqW-1:0]  out_freq_q;
  logic              out_unstable_q;

  logic              in_acc;
  logic              div_start;
  logic              div_done;
  logic [NumW-1:0]   quotient;
  logic              load_out;
  logic [FreqW-1:0]  product;
  logic [WideW-1:0]  f_w;
  logic [WideW-1:0]  p_w;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign div_start  = in_acc && period_mode_q && (in_i.kind == KIND_PERIOD)
                      && (in_i.count != '0);
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  assign product    = FreqW'(count_q) * FreqW'(gate_scale(meter_q, gate_q));
  assign f_w        = {{(WideW-FreqW){1'b0}}, freq_q};
  assign p_w        = {{(WideW-FreqW){1'b0}}, prev_q};

  fpcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (period_numerator(meter_q, ref_q, per_q)),
    .divisor_i  (in_i.count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meter_q <= 1'b1;
      gate_q  <= '0;
      ref_q   <= '0;
      per_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_METER:   meter_q <= cfg_data_i[0];
        CFG_GATE:    gate_q  <= cfg_data_i;
        CFG_REF:     ref_q   <= cfg_data_i;
        CFG_PERIODS: per_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      period_mode_q <= 1'b0;
      prev_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (!period_mode_q) begin
              if (in_i.kind == KIND_FREQ) begin
                if (in_i.count < LowCountLimit) begin
                  period_mode_q <= 1'b1;
                end else begin
                  state_q <= ST_MUL;
                end
              end
            end else if (in_i.kind == KIND_PERIOD) begin
              period_mode_q <= 1'b0;
              state_q       <= (in_i.count == '0) ? ST_SCALE : ST_DIV;
            end
          end
        end
        ST_MUL: state_q <= ST_SCALE;
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: state_q <= ST_DONE;
        ST_DONE: begin
          if (load_out) begin
            prev_q  <= freq_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      count_q <= in_i.count;
      freq_q  <= '0;
    end
    if (state_q == ST_MUL) begin
      freq_q <= product;
    end
    if ((state_q == ST_DIV) && div_done) begin
      freq_q <= {{(FreqW-NumW){1'b0}}, quotient};
    end
    if (state_q == ST_SCALE) begin
      f10_q <= (f_w << 3) + (f_w << 1);
      p9_q  <= (p_w << 3) + p_w;
      p11_q <= (p_w << 3) + (p_w << 1) + p_w;
    end
    if (load_out) begin
      out_freq_q     <= freq_q;
      out_unstable_q <= (f10_q < p9_q) || (f10_q > p11_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.frequency_mhz = out_freq_q;
  assign out_o.unstable      = out_unstable_q;

endmodule

// ----- design/fpcs_div.sv -----
// ----------------------------------------------------------------------------
// Frequency/period counter select divider
// Restoring divider, one quotient bit per cycle through one subtractor.
// ----------------------------------------------------------------------------
module fpcs_div
  import fpcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NumW-1:0]   dividend_i,
  input  logic [CountW-1:0] divisor_i,
  output logic              done_o,
  output logic [NumW-1:0]   quotient_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [CountW-1:0] rem_q;
  logic [CountW-1:0] dvs_q;
  logic [NumW-1:0]   quo_q;

  logic [CountW:0]   rem_shift;
  logic [CountW:0]   rem_diff;
  logic              take;

  assign rem_shift = {rem_q, quo_q[NumW-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs_q};
  assign take      = (rem_shift >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= take ? rem_diff[CountW-1:0] : rem_shift[CountW-1:0];
      quo_q <= {quo_q[NumW-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frequency/period counter select testbench
// Sends frequency and period counts through the count channel under several
// register settings and idling patterns, predicts each frequency result and
// its stability flag, and checks every result item in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import fpcs_pkg::*;

  localparam int QuietLimit   = 4000;
  localparam int SettleCycles = 64;
  localparam logic [63:0] FreqMax = (64'd1 << FreqW) - 64'd1;

  class freq_scoreboard;
    typedef struct packed {
      logic [FreqW-1:0] freq;
      logic             unstable;
    } result_t;

    logic             meter_on;
    logic [1:0]       gate_sel;
    logic [1:0]       refclk_sel;
    logic [1:0]       periods_sel;
    bit               period_mode;
    logic [63:0]      last_freq;
    result_t          expected_q[$];
    int               errors;

    function new();
      meter_on    = 1'b1;
      gate_sel    = 2'd0;
      refclk_sel  = 2'd0;
      periods_sel = 2'd0;
      period_mode = 1'b0;
      last_freq   = '0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [1:0] data);
      case (idx)
        CFG_METER:   meter_on = data[0];
        CFG_GATE:    gate_sel = data;
        CFG_REF:     refclk_sel = data;
        CFG_PERIODS: periods_sel = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] freq_from_gate(logic [CountW-1:0] count);
      logic [63:0] per_count;
      if (!meter_on || gate_sel == 2'd0) begin
        per_count = 64'd10000;
      end else if (gate_sel == 2'd1) begin
        per_count = 64'd1000;
      end else begin
        per_count = 64'd100;
      end
      return 64'(count) * per_count;
    endfunction

    function logic [63:0] freq_from_period(logic [CountW-1:0] count);
      logic [63:0] num;
      int          decades;
      if (count == '0) return 64'd0;
      if (!meter_on) begin
        num = 64'd1_000_000_000;
      end else begin
        // The slowest reference with one period averaged, in millihertz.
        num = 64'd100_000_000;
        decades = int'(refclk_sel) + ((periods_sel == 2'd3) ? 2 : int'(periods_sel));
        repeat (decades) num = num * 64'd10;
      end
      return num / 64'(count);
    endfunction

    function void note_count(kind_e kind, logic [CountW-1:0] count);
      logic [63:0] f;
      logic [63:0] prev;
      if (!period_mode) begin
        if (kind != KIND_FREQ) return;
        if (count < LowCountLimit) begin
          period_mode = 1'b1;
          return;
        end
        f = freq_from_gate(count);
      end else begin
        if (kind != KIND_PERIOD) return;
        f = freq_from_period(count);
        period_mode = 1'b0;
      end
      if (f > FreqMax) f = FreqMax;
      prev = last_freq;
      expected_q.push_back(result_t'{freq: f[FreqW-1:0],
          unstable: (64'd10 * f < 64'd9 * prev) || (64'd10 * f > 64'd11 * prev)});
      last_freq = f;
    endfunction

    function void check_result(logic [FreqW-1:0] freq, logic unstable);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result item: freq %0d unstable %0b", freq, unstable);
        end
        return;
      end
      want = expected_q.pop_front();
      if (want.freq !== freq || want.unstable !== unstable) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected freq %0d unstable %0b, got freq %0d unstable %0b",
                   want.freq, want.unstable, freq, unstable);
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  fpcs_in_if  in_if ();
  fpcs_out_if out_if ();

  freq_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  logic [CountW-1:0] gate_count_hist   = 32'd5000;
  logic [CountW-1:0] period_count_hist = 32'd100;

  freq_period_counter_select u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      sb.note_count(kind_e'(in_if.kind), in_if.count);
    end
    if (out_if.valid && out_if.ready) begin
      sb.check_result(out_if.frequency_mhz, out_if.unstable);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i ||
        !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    out_if.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      out_if.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_count(kind_e kind, logic [CountW-1:0] count);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.kind  = kind;
    in_if.count = count;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apply_settings(logic [1:0] meter, logic [1:0] gate, logic [1:0] refclk,
                                logic [1:0] periods);
    logic [1:0] vals [4];
    vals = '{meter, gate, refclk, periods};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   = 1'b1;
      cfg_idx_i  = cfg_idx_e'(i);
      cfg_data_i = vals[i];
      @(posedge clk_i);
      sb.set_reg(cfg_idx_e'(i), vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_quiet();
    in_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [CountW-1:0] nudge(logic [CountW-1:0] v);
    logic [63:0] x;
    x = 64'(v) * 64'($urandom_range(88, 112)) / 64'd100;
    return (x > 64'hFFFF_FFFF) ? '1 : x[CountW-1:0];
  endfunction

  function automatic logic [CountW-1:0] spread_count();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  task automatic run_directed();
    send_count(KIND_FREQ, 32'd1000);
    send_count(KIND_FREQ, 32'd1000);
    send_count(KIND_FREQ, 32'd1100);
    send_count(KIND_FREQ, 32'd1211);
    send_count(KIND_FREQ, 32'd2000);
    send_count(KIND_FREQ, 32'd1800);
    send_count(KIND_FREQ, 32'd1619);
    send_count(KIND_FREQ, 32'hFFFF_FFFF);
    send_count(KIND_PERIOD, 32'd1234);
    send_count(KIND_FREQ, 32'd999);
    send_count(KIND_FREQ, 32'd5);
    send_count(KIND_PERIOD, 32'd0);
    send_count(KIND_FREQ, 32'd0);
    send_count(KIND_PERIOD, 32'd1);
    send_count(KIND_FREQ, 32'd500);
    send_count(KIND_PERIOD, 32'hFFFF_FFFF);
    send_count(KIND_FREQ, 32'd1);
    send_count(KIND_PERIOD, 32'd3);
    send_count(KIND_FREQ, 32'd0);
    send_count(KIND_PERIOD, 32'd3);
  endtask

  task automatic run_random(int n);
    int                done;
    int                pick;
    kind_e             kind;
    logic [CountW-1:0] count;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (!sb.period_mode) begin
        if (pick < 8) begin
          kind  = KIND_PERIOD;
          count = $urandom;
        end else begin
          kind = KIND_FREQ;
          if (pick < 25) begin
            count = $urandom_range(0, 999);
          end else if (pick < 65) begin
            count = nudge(gate_count_hist);
            if (count < LowCountLimit) count = LowCountLimit;
          end else begin
            count = spread_count();
          end
          if (count >= LowCountLimit) gate_count_hist = count;
        end
      end else begin
        if (pick < 8) begin
          kind  = KIND_FREQ;
          count = $urandom;
        end else begin
          kind = KIND_PERIOD;
          if (pick < 12) begin
            count = '0;
          end else if (pick < 55) begin
            count = nudge(period_count_hist);
          end else begin
            count = spread_count();
          end
          if (count != '0) period_count_hist = count;
        end
      end
      if (kind == (sb.period_mode ? KIND_PERIOD : KIND_FREQ)) done++;
      send_count(kind, count);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.kind  = KIND_FREQ;
    in_if.count = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_METER;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       apply_settings(2'd1, 2'd0, 2'd0, 2'd0);
        1:       apply_settings(2'd1, 2'd2, 2'd3, 2'd2);
        2:       apply_settings(2'd2, 2'd1, 2'd1, 2'd1);
        3:       apply_settings(2'd3, 2'd3, 2'd3, 2'd3);
        4:       apply_settings(2'd0, 2'd0, 2'd0, 2'd0);
        default: apply_settings(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 81;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 81;
        end
        default: begin
          send_idle_pct = 22;
          stall_pct     = 22;
        end
      endcase
      if (phase == 0) run_directed();
      run_random(195);
      wait_quiet();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
